// ----- src/pklbs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pass key blink sequencer package
// Shared widths, reset values, codes and transaction types.
// ----------------------------------------------------------------------------
package pklbs_pkg;

    localparam int unsigned DIGITS_DEF = 6;

    localparam int unsigned KEY_W     = 20;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned DIG_W     = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Reciprocal of ten, scaled by 2^DIV10_SHIFT and rounded up;
    // exact quotient for any KEY_W-bit dividend
    localparam int unsigned            DIV10_SHIFT = 23;
    localparam logic [KEY_W-1:0]       DIV10_MAGIC = 20'd838861;
    localparam int unsigned            QUOT_W      = KEY_W - 3;

    localparam logic [TICK_W-1:0] ON_TICKS_RST    = 16'd4000;
    localparam logic [TICK_W-1:0] OFF_TICKS_RST   = 16'd10000;
    localparam logic [TICK_W-1:0] PAUSE_TICKS_RST = 16'd42000;

    localparam logic [CNT_W-1:0] ZERO_DIGIT_BLINKS = 4'd10;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_TICKS    = 2'd0,
        CFG_OFF_TICKS   = 2'd1,
        CFG_PAUSE_TICKS = 2'd2
    } pklbs_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_TICK,
        ST_DONE
    } pklbs_state_t;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key_code;
    } pklbs_req_t;

    typedef struct packed {
        logic             led_lit;
        logic             busy_res;
        logic [DIG_W-1:0] digit_index;
        logic             finished;
    } pklbs_rsp_t;

endpackage : pklbs_pkg
`default_nettype wire

// ----- src/pklbs_div10.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Divide by ten
// Quotient and remainder of a key by ten through a reciprocal multiply.
// ----------------------------------------------------------------------------
module pklbs_div10
(
    input  wire logic [pklbs_pkg::KEY_W-1:0] dividend,
    output logic      [pklbs_pkg::KEY_W-1:0] quotient,
    output logic      [pklbs_pkg::CNT_W-1:0] remainder
);
    import pklbs_pkg::*;

    logic [2*KEY_W-1:0]  product;
    logic [QUOT_W-1:0]   quot_short;
    logic [KEY_W-1:0]    times_ten;
    logic [KEY_W-1:0]    diff;

    assign product    = dividend * DIV10_MAGIC;
    assign quot_short = product[DIV10_SHIFT +: QUOT_W];
    assign quotient   = KEY_W'(quot_short);
    // q * 10 as (q << 3) + (q << 1)
    assign times_ten  = {quotient[KEY_W-4:0], 3'b000} + {quotient[KEY_W-2:0], 1'b0};
    assign diff       = dividend - times_ten;
    assign remainder  = diff[CNT_W-1:0];

endmodule : pklbs_div10
`default_nettype wire

// ----- src/passkey_led_blink_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pass key LED blink sequencer
// Shows a decimal pass key as groups of LED blinks, one group per digit.
// ----------------------------------------------------------------------------
// A start transaction (func = 1) splits the key into decimal digits one per
// cycle through a single shared divide-by-ten unit; a tick transaction is
// func = 0. One transaction is in flight at a time; req_ready is high only
// while the sequencer is idle. A pending response waits in an output
// register, so the next request can be taken before it is collected.
// Configuration writes are always accepted; out-of-range indexes are dropped.
module passkey_led_blink_sequencer
#(
    parameter int unsigned DIGITS = pklbs_pkg::DIGITS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire pklbs_pkg::pklbs_req_t           req,

    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output pklbs_pkg::pklbs_rsp_t                rsp,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pklbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pklbs_pkg::TICK_W-1:0]    cfg_data
);
    import pklbs_pkg::*;

    localparam int unsigned      IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP  = IDX_W'(DIGITS - 1);
    localparam logic [DIG_W-1:0] DIGIT_END  = DIG_W'(DIGITS);

    pklbs_state_t       state_reg, state_next;

    logic [TICK_W-1:0]  on_ticks_reg, off_ticks_reg, pause_ticks_reg;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   digits_reg [DIGITS];
    logic [CNT_W-1:0]   blink_cnt_reg, blink_cnt_next;
    logic [DIG_W-1:0]   digit_reg, digit_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [TICK_W-1:0]  target_reg, target_next;
    logic               led_reg, led_next;
    logic               run_reg, run_next;
    logic               fin_reg, fin_next;
    pklbs_rsp_t         rsp_reg;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               req_fire;
    logic               rsp_load;
    logic               dig_we;
    logic [IDX_W-1:0]   dig_idx;
    logic [CNT_W-1:0]   dig_val;

    logic [KEY_W-1:0]   div_q;
    logic [CNT_W-1:0]   div_r;
    logic [IDX_W-1:0]   wr_idx;
    logic [CNT_W-1:0]   conv_blinks;
    logic [TICK_W-1:0]  tick_inc;
    logic [DIG_W-1:0]   digit_inc;
    logic [IDX_W-1:0]   nxt_idx;

    pklbs_div10 u_div10
    (
        .dividend  (key_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid & req_ready;
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Digits come out least significant first; store them from the far end
    assign wr_idx      = LAST_STEP - step_reg;
    assign conv_blinks = (div_r == '0) ? ZERO_DIGIT_BLINKS : div_r;
    assign tick_inc    = tick_reg + 1'b1;
    assign digit_inc   = digit_reg + 1'b1;
    assign nxt_idx     = digit_inc[IDX_W-1:0];

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.func == FUNC_START) ? ST_CONV : ST_TICK;
                end
            end
            ST_CONV:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TICK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath control
    // ------------------------------------------------------------------------
    always_comb
    begin
        key_next       = key_reg;
        step_next      = step_reg;
        blink_cnt_next = blink_cnt_reg;
        digit_next     = digit_reg;
        tick_next      = tick_reg;
        target_next    = target_reg;
        led_next       = led_reg;
        run_next       = run_reg;
        fin_next       = fin_reg;
        dig_we         = 1'b0;
        dig_idx        = wr_idx;
        dig_val        = conv_blinks;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    key_next  = req.key_code;
                    step_next = '0;
                end
            end
            ST_CONV:
            begin
                key_next  = div_q;
                step_next = step_reg + 1'b1;
                dig_we    = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    // First digit is ready now: light the LED for its first blink
                    blink_cnt_next = conv_blinks - 1'b1;
                    digit_next     = '0;
                    led_next       = 1'b1;
                    tick_next      = '0;
                    target_next    = on_ticks_reg;
                    run_next       = 1'b1;
                    fin_next       = 1'b0;
                end
            end
            ST_TICK:
            begin
                fin_next = 1'b0;
                if (run_reg)
                begin
                    tick_next = tick_inc;
                    if (tick_inc == target_reg)
                    begin
                        tick_next = '0;
                        if (led_reg)
                        begin
                            led_next = 1'b0;
                            if (blink_cnt_reg == '0)
                            begin
                                digit_next = digit_inc;
                                if (digit_inc == DIGIT_END)
                                begin
                                    run_next = 1'b0;
                                    fin_next = 1'b1;
                                end
                                else
                                begin
                                    target_next    = pause_ticks_reg;
                                    blink_cnt_next = digits_reg[nxt_idx] - 1'b1;
                                end
                            end
                            else
                            begin
                                target_next    = off_ticks_reg;
                                blink_cnt_next = blink_cnt_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            led_next    = 1'b1;
                            target_next = on_ticks_reg;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                key_next = key_reg;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            blink_cnt_reg <= '0;
            digit_reg     <= '0;
            tick_reg      <= '0;
            target_reg    <= '0;
            led_reg       <= 1'b0;
            run_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            blink_cnt_reg <= blink_cnt_next;
            digit_reg     <= digit_next;
            tick_reg      <= tick_next;
            target_reg    <= target_next;
            led_reg       <= led_next;
            run_reg       <= run_next;
            fin_reg       <= fin_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg    <= ON_TICKS_RST;
            off_ticks_reg   <= OFF_TICKS_RST;
            pause_ticks_reg <= PAUSE_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ON_TICKS:    on_ticks_reg    <= cfg_data;
                CFG_OFF_TICKS:   off_ticks_reg   <= cfg_data;
                CFG_PAUSE_TICKS: pause_ticks_reg <= cfg_data;
                default:
                begin
                    // drop writes to unknown registers
                    on_ticks_reg <= on_ticks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (dig_we)
        begin
            digits_reg[dig_idx] <= dig_val;
        end
        if (rsp_load)
        begin
            rsp_reg.led_lit     <= led_reg;
            rsp_reg.busy_res    <= run_reg;
            rsp_reg.digit_index <= digit_reg;
            rsp_reg.finished    <= fin_reg;
        end
    end

endmodule : passkey_led_blink_sequencer
`default_nettype wire
